// ===== hw/rtl/mrprb_pkg.sv =====
package mrprb_pkg;

   localparam int PACKETS     = 16;
   localparam int SLOTS       = 8;
   localparam int READERS     = 3;
   localparam int SCALE_SHIFT = 18;

   localparam int PKT_W  = (PACKETS > 1) ? $clog2(PACKETS) : 1;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RDR_W  = (READERS > 1) ? $clog2(READERS) : 1;
   localparam int ADDR_W = $clog2(PACKETS * SLOTS);
   // word counter: id, stamp, then SLOTS readings
   localparam int LAST_CNT = SLOTS + 1;
   localparam int CNT_W    = $clog2(LAST_CNT + 1);

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_READ   = 1'b1;

   localparam logic [1:0] KIND_ID      = 2'd0;
   localparam logic [1:0] KIND_STAMP   = 2'd1;
   localparam logic [1:0] KIND_READING = 2'd2;

   typedef struct packed {
      logic sample_take;
      logic read_start;
      logic emit;
      logic emit_none;
   } mrprb_cmd_type;

   typedef struct packed {
      logic empty;
      logic last_word;
      logic out_free;
   } mrprb_stat_type;

endpackage

// ===== hw/rtl/mrprb_ctrl.sv =====
module mrprb_ctrl
   import mrprb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_action,
   input  mrprb_stat_type stat,
   output mrprb_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_STREAM = 2'd1;
   localparam logic [1:0] ST_NONE   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      cmd             = '0;
      state_in        = state_ff;
      cmd.sample_take = req_take && (req_action == ACTION_SAMPLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_action == ACTION_READ)) begin
               if (stat.empty) begin
                  state_in = ST_NONE;
               end else begin
                  cmd.read_start = 1'b1;
                  state_in       = ST_STREAM;
               end
            end
         end
         ST_STREAM: begin
            cmd.emit = stat.out_free;
            if (stat.out_free && stat.last_word) begin
               state_in = ST_IDLE;
            end
         end
         ST_NONE: begin
            cmd.emit_none = stat.out_free;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !(cmd.sample_take || cmd.read_start))
      else $error("transaction accepted while a response is in flight");
   a_stream_exit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.last_word) |=> (state_ff == ST_IDLE))
      else $error("stream did not end after last word");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.sample_take, cmd.read_start, cmd.emit, cmd.emit_none}))
      else $error("conflicting datapath commands");
`endif

endmodule

// ===== hw/rtl/mrprb_datapath.sv =====
module mrprb_datapath
   import mrprb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mrprb_cmd_type      cmd,
   output mrprb_stat_type     stat,
   input  logic [1:0]         req_reader,
   input  logic [15:0]        req_filter_count,
   input  logic signed [63:0] req_filtered_value,
   input  logic [63:0]        req_timestamp,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_packet_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_has_data,
   output logic [1:0]         rsp_word_kind,
   output logic [2:0]         rsp_slot_index,
   output logic [63:0]        rsp_word_value,
   output logic               rsp_last
);

   logic [63:0]       stamp_mem_ff   [PACKETS];
   logic [31:0]       reading_mem_ff [PACKETS*SLOTS];
   logic [63:0]       stamp_rd_ff;
   logic [31:0]       reading_rd_ff;

   logic [15:0]       packet_id_ff;
   logic [15:0]       prev_count_ff;
   logic [SLOT_W-1:0] fill_slot_ff;
   logic [SLOT_W-1:0] fill_slot_in;
   logic [PKT_W-1:0]  write_packet_ff;
   logic [PKT_W-1:0]  write_packet_in;
   logic [PKT_W-1:0]  positions_ff [READERS];
   logic [PKT_W-1:0]  pos_ff;
   logic [PKT_W-1:0]  pos_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;

   logic              rsp_valid_ff;
   logic              rsp_has_data_ff;
   logic [1:0]        rsp_word_kind_ff;
   logic [2:0]        rsp_slot_index_ff;
   logic [63:0]       rsp_word_value_ff;
   logic              rsp_last_ff;

   logic [RDR_W-1:0]  rdr_idx;
   logic              rdr_ok;
   logic [PKT_W-1:0]  sel_pos;
   logic [PKT_W-1:0]  sel_pos_next;
   logic              sample_new;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [SLOT_W-1:0] rd_slot;
   logic [SLOT_W-1:0] cur_slot;

   assign csr_ready = 1'b1;

   // reader selection and emptiness check at accept
   assign rdr_idx      = RDR_W'(req_reader);
   assign rdr_ok       = (int'(req_reader) < READERS);
   assign sel_pos      = rdr_ok ? positions_ff[rdr_idx] : '0;
   assign sel_pos_next = (sel_pos == PKT_W'(PACKETS - 1)) ? '0 : sel_pos + PKT_W'(1);

   assign stat.empty     = !rdr_ok || (sel_pos == write_packet_ff);
   assign stat.last_word = (cnt_ff == CNT_W'(LAST_CNT));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // sample path
   assign sample_new = cmd.sample_take && (req_filter_count != prev_count_ff);
   assign wr_addr    = ADDR_W'(int'(write_packet_ff) * SLOTS + int'(fill_slot_ff));

   always_comb begin
      fill_slot_in    = fill_slot_ff;
      write_packet_in = write_packet_ff;
      if (sample_new) begin
         if (fill_slot_ff == SLOT_W'(SLOTS - 1)) begin
            fill_slot_in    = '0;
            write_packet_in = (write_packet_ff == PKT_W'(PACKETS - 1)) ? '0 :
                              write_packet_ff + PKT_W'(1);
         end else begin
            fill_slot_in = fill_slot_ff + SLOT_W'(1);
         end
      end
   end

   // read address looks ahead at next counter so data lines up with cnt_ff
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.read_start) begin
         cnt_in = '0;
      end else if (cmd.emit && !stat.last_word) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   assign pos_in   = cmd.read_start ? sel_pos : pos_ff;
   assign rd_slot  = SLOT_W'(cnt_in - CNT_W'(2));
   assign rd_addr  = ADDR_W'(int'(pos_in) * SLOTS + int'(rd_slot));
   assign cur_slot = SLOT_W'(cnt_ff - CNT_W'(2));

   always_ff @(posedge clock) begin
      if (sample_new && (fill_slot_ff == '0)) begin
         stamp_mem_ff[write_packet_ff] <= req_timestamp;
      end
      stamp_rd_ff <= stamp_mem_ff[pos_in];
   end

   always_ff @(posedge clock) begin
      if (sample_new) begin
         reading_mem_ff[wr_addr] <=
            req_filtered_value[SCALE_SHIFT+31:SCALE_SHIFT];
      end
      reading_rd_ff <= reading_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_id_ff    <= '0;
         prev_count_ff   <= '0;
         fill_slot_ff    <= '0;
         write_packet_ff <= '0;
         cnt_ff          <= '0;
         pos_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < READERS; i++) begin
            positions_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            packet_id_ff <= csr_packet_id;
         end
         if (sample_new) begin
            prev_count_ff <= req_filter_count;
         end
         fill_slot_ff    <= fill_slot_in;
         write_packet_ff <= write_packet_in;
         cnt_ff          <= cnt_in;
         pos_ff          <= pos_in;
         if (cmd.read_start) begin
            positions_ff[rdr_idx] <= sel_pos_next;
         end
         if (cmd.emit || cmd.emit_none) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.emit_none) begin
         rsp_has_data_ff   <= 1'b0;
         rsp_word_kind_ff  <= KIND_ID;
         rsp_slot_index_ff <= '0;
         rsp_word_value_ff <= '0;
         rsp_last_ff       <= 1'b1;
      end else if (cmd.emit) begin
         rsp_has_data_ff <= 1'b1;
         rsp_last_ff     <= stat.last_word;
         if (cnt_ff == '0) begin
            rsp_word_kind_ff  <= KIND_ID;
            rsp_slot_index_ff <= '0;
            rsp_word_value_ff <= 64'(packet_id_ff);
         end else if (cnt_ff == CNT_W'(1)) begin
            rsp_word_kind_ff  <= KIND_STAMP;
            rsp_slot_index_ff <= '0;
            rsp_word_value_ff <= stamp_rd_ff;
         end else begin
            rsp_word_kind_ff  <= KIND_READING;
            rsp_slot_index_ff <= 3'(cur_slot);
            rsp_word_value_ff <= 64'(reading_rd_ff);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_data   = rsp_has_data_ff;
   assign rsp_word_kind  = rsp_word_kind_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_word_value = rsp_word_value_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_none) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while stalled");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(LAST_CNT))
      else $error("word counter out of range");
   a_ring_range: assert property (@(posedge clock) disable iff (reset)
      (int'(write_packet_ff) < PACKETS) && (int'(fill_slot_ff) < SLOTS))
      else $error("write pointer out of range");
   a_start_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.read_start |=> (cnt_ff == '0) && !rsp_last_ff || (cnt_ff == '0))
      else $error("word counter not cleared at read start");
`endif

endmodule

// ===== hw/rtl/multi_reader_packet_ring_buffer_unit.sv =====
// channel  | ports                          | direction | payload
// req      | req_valid / req_ready          | in        | action, reader, count, value, stamp
// rsp      | rsp_valid / rsp_ready          | out       | has_data, kind, slot, value, last
// csr      | csr_valid / csr_ready          | in        | packet_id
//
// A sample is taken on accept. A read is accepted, then streams
// SLOTS+2 words (10 words here), one per cycle while rsp is not stalled;
// the per-word rate is set by the single response register, refilled as it
// drains, with the readings memory fetched one word ahead.
// A reader with nothing new gets one word: the accept moves the control to
// its none state, which then loads the response register with that word.
// Reset is synchronous; memories are not cleared. rsp stalls hold the stream.
module multi_reader_packet_ring_buffer_unit
   import mrprb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic [1:0]         req_reader,
   input  logic [15:0]        req_filter_count,
   input  logic signed [63:0] req_filtered_value,
   input  logic [63:0]        req_timestamp,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_has_data,
   output logic [1:0]         rsp_word_kind,
   output logic [2:0]         rsp_slot_index,
   output logic [63:0]        rsp_word_value,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_packet_id
);

   mrprb_cmd_type  cmd;
   mrprb_stat_type stat;

   mrprb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   mrprb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_reader         (req_reader),
      .req_filter_count   (req_filter_count),
      .req_filtered_value (req_filtered_value),
      .req_timestamp      (req_timestamp),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_packet_id      (csr_packet_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_has_data       (rsp_has_data),
      .rsp_word_kind      (rsp_word_kind),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_word_value     (rsp_word_value),
      .rsp_last           (rsp_last)
   );

endmodule
